// ----- rtl/core/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the port checker.
// Depends on nothing; included by the bound checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define NBW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("nbw assertion failed");

// When cond holds, prop holds on the next clock edge.
`define NBW_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("nbw assertion failed");

`endif

// ----- rtl/core/nbw_pkg.sv -----
// nbw_pkg: types, sizes and codes of the nearest bone weighting block.
// Depends on nothing; imported by the top level, the square root, the divider and the checkers.
package nbw_pkg;

	localparam int MAX_BONES = 64;
	localparam int MAX_KEPT  = 4;

	localparam int BONE_AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int BONE_CW = $clog2(MAX_BONES + 1);
	localparam int KEPT_AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int KEPT_CW = $clog2(MAX_KEPT + 1);

	localparam int COORD_W = 32;
	localparam int DIST_W  = 32;
	localparam int SQ_W    = 64;
	localparam int DIV_NW  = 64;
	localparam int DIV_DW  = 48;
	localparam int INV_W   = 48;
	localparam int WGT_W   = 17;
	localparam int INV_SHIFT = 44;

	localparam logic [DIST_W-1:0] DIST_EPS = 32'd7;
	localparam logic [WGT_W-1:0]  ONE_Q16  = 17'd65536;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Config register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BONES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_INFL  = 2'd1;

	typedef struct packed {
		logic               command;
		logic [5:0]         bone_slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} item_t;

	typedef struct packed {
		logic [5:0]  bone_index;
		logic [16:0] weight;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_ACC,
		ST_SQS,
		ST_SQW,
		ST_INV,
		ST_INVW,
		ST_NORM,
		ST_NORMW
	} state_t;

endpackage

// ----- rtl/core/nearest_bone_weighting.sv -----
// nearest_bone_weighting: k-nearest inverse distance bone weighting.
// Load beat: start with command load writes one bone entry; busy stays low.
// Query beat: start with command query begins a scan over the first num_bones
// bones (at most MAX_BONES); busy stays high until the last result has been strobed.
// Channels: start/busy input command, strobe/result output (one cycle each,
// no back pressure), cfg_valid/cfg_ready register write port (always ready).
// Work of a query: per bone one RAM read, three passes through the shared
// squaring multiplier, one accumulate and the bit-serial square root; then
// per kept bone two 64 step divisions (inverse distance, then normalization).
// One query at a time.
// Results come out nearest first, one per normalization, with last on the
// final one. A query with no bones gives no results and ends at once.
// Reset clears the sequencer and the config registers (num_bones 0,
// max_influences 4); bone entries stay undefined until loaded.
// Depends on nbw_pkg, nbw_ram, nbw_isqrt, nbw_div.
module nearest_bone_weighting import nbw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 strobe,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]           cfg_data
);

	localparam int RAM_W = 3 * COORD_W;

	state_t state_q, state_n;

	logic [6:0]         num_bones_q;
	logic [2:0]         max_infl_q;
	logic [BONE_CW-1:0] n_q;
	logic [KEPT_CW-1:0] k_q;
	logic [BONE_AW-1:0] idx_q;
	logic [KEPT_AW-1:0] j_q;
	logic [KEPT_CW-1:0] count_q;
	logic [COORD_W-1:0] px_q, py_q, pz_q;

	logic [DIST_W-1:0]  kd_q  [MAX_KEPT];
	logic [BONE_AW-1:0] ki_q  [MAX_KEPT];
	logic [INV_W-1:0]   inv_q [MAX_KEPT];
	logic [INV_W-1:0]   total_q;

	logic [SQ_W:0]   prod_q;
	logic [SQ_W-1:0] acc_q;
	logic            strobe_q;
	result_t         result_q;

	logic accept, acc_load, acc_query;
	logic ram_we;
	logic [RAM_W-1:0] ram_rd;

	// Config writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bones_q <= '0;
			max_infl_q  <= 3'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_BONES: num_bones_q <= cfg_data;
				CFG_MAX_INFL:  max_infl_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign acc_load  = accept && (item.command == CMD_LOAD);
	assign acc_query = accept && (item.command == CMD_QUERY);
	assign ram_we    = acc_load && (int'(item.bone_slot) < MAX_BONES);

	// Bone store, {x, y, z} per entry
	nbw_ram #(.WIDTH(RAM_W), .DEPTH(MAX_BONES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (BONE_AW'(item.bone_slot)),
		.wdata ({item.pos_x, item.pos_y, item.pos_z}),
		.raddr (idx_q),
		.rdata (ram_rd)
	);

	// Clamped counts for a new query
	logic [BONE_CW-1:0] n_new;
	logic [KEPT_CW-1:0] k_new;

	always_comb begin
		n_new = (int'(num_bones_q) > MAX_BONES) ? BONE_CW'(MAX_BONES) : BONE_CW'(num_bones_q);
		if (max_infl_q == 3'd0) begin
			k_new = KEPT_CW'(1);
		end else if (int'(max_infl_q) > MAX_KEPT) begin
			k_new = KEPT_CW'(MAX_KEPT);
		end else begin
			k_new = KEPT_CW'(max_infl_q);
		end
	end

	// Shared squaring unit: one axis difference per cycle
	logic [COORD_W-1:0] sel_p, sel_b;
	logic [COORD_W:0]   diff, mag;
	logic [2*COORD_W+1:0] sq_full;
	logic [SQ_W+1:0]    sat_sum;
	logic [SQ_W-1:0]    acc_sat;

	always_comb begin
		case (state_q)
			ST_MY:   begin sel_p = py_q; sel_b = ram_rd[COORD_W +: COORD_W]; end
			ST_MZ:   begin sel_p = pz_q; sel_b = ram_rd[0 +: COORD_W]; end
			default: begin sel_p = px_q; sel_b = ram_rd[2*COORD_W +: COORD_W]; end
		endcase
		diff    = {sel_p[COORD_W-1], sel_p} - {sel_b[COORD_W-1], sel_b};
		mag     = diff[COORD_W] ? (~diff + 1'b1) : diff;
		sq_full = {{(COORD_W+1){1'b0}}, mag} * {{(COORD_W+1){1'b0}}, mag};
		sat_sum = {2'b00, acc_q} + {1'b0, prod_q};
		acc_sat = (sat_sum[SQ_W+1:SQ_W] != 2'b00) ? '1 : sat_sum[SQ_W-1:0];
	end

	// Square root and divider units
	logic              sq_start, sq_done;
	logic [DIST_W-1:0] sq_root;
	logic              dv_start, dv_done;
	logic [DIV_NW-1:0] dv_num, dv_quo;
	logic [DIV_DW-1:0] dv_den;

	nbw_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (acc_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	nbw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	// Insertion point in the kept list: first entry strictly farther
	logic [KEPT_CW-1:0] far_cnt, ins_pos, cnt_new;
	logic               ins_take;

	always_comb begin
		far_cnt = '0;
		for (int j = 0; j < MAX_KEPT; j++) begin
			if ((KEPT_CW'(j) < count_q) && (kd_q[j] > sq_root)) begin
				far_cnt = far_cnt + 1'b1;
			end
		end
		ins_pos  = count_q - far_cnt;
		ins_take = (ins_pos < k_q);
		cnt_new  = (count_q < k_q) ? KEPT_CW'(count_q + 1'b1) : count_q;
	end

	logic bone_last, kept_last;
	assign bone_last = (BONE_CW'(BONE_CW'(idx_q) + 1'b1) == n_q);
	assign kept_last = (KEPT_CW'(KEPT_CW'(j_q) + 1'b1) == count_q);

	// Divider operands
	always_comb begin
		if (state_q == ST_NORM) begin
			dv_num = DIV_NW'({inv_q[j_q], 16'b0}) + DIV_NW'(total_q >> 1);
			dv_den = DIV_DW'(total_q);
		end else begin
			dv_num = DIV_NW'(1) << INV_SHIFT;
			dv_den = DIV_DW'(kd_q[j_q]) + DIV_DW'(DIST_EPS);
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and unit strobes
	always_comb begin
		state_n  = state_q;
		sq_start = 1'b0;
		dv_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_query && (n_new != '0)) state_n = ST_READ;
			end
			ST_READ: state_n = ST_MX;
			ST_MX:   state_n = ST_MY;
			ST_MY:   state_n = ST_MZ;
			ST_MZ:   state_n = ST_ACC;
			ST_ACC:  state_n = ST_SQS;
			ST_SQS: begin
				sq_start = 1'b1;
				state_n  = ST_SQW;
			end
			ST_SQW: begin
				if (sq_done) state_n = bone_last ? ST_INV : ST_READ;
			end
			ST_INV: begin
				dv_start = 1'b1;
				state_n  = ST_INVW;
			end
			ST_INVW: begin
				if (dv_done) state_n = kept_last ? ST_NORM : ST_INV;
			end
			ST_NORM: begin
				dv_start = 1'b1;
				state_n  = ST_NORMW;
			end
			ST_NORMW: begin
				if (dv_done) state_n = kept_last ? ST_IDLE : ST_NORM;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Sequencer counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			j_q      <= '0;
			count_q  <= '0;
			n_q      <= '0;
			k_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_query) begin
						idx_q   <= '0;
						j_q     <= '0;
						count_q <= '0;
						n_q     <= n_new;
						k_q     <= k_new;
					end
				end
				ST_SQW: begin
					if (sq_done) begin
						if (ins_take) count_q <= cnt_new;
						idx_q <= BONE_AW'(idx_q + 1'b1);
					end
				end
				ST_INVW: begin
					if (dv_done) j_q <= kept_last ? '0 : KEPT_AW'(j_q + 1'b1);
				end
				ST_NORMW: begin
					if (dv_done) begin
						strobe_q <= 1'b1;
						j_q      <= KEPT_AW'(j_q + 1'b1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_query) begin
					px_q    <= item.pos_x;
					py_q    <= item.pos_y;
					pz_q    <= item.pos_z;
					total_q <= '0;
				end
			end
			ST_MX: begin
				prod_q <= sq_full[SQ_W:0];
				acc_q  <= '0;
			end
			ST_MY, ST_MZ: begin
				prod_q <= sq_full[SQ_W:0];
				acc_q  <= acc_sat;
			end
			ST_ACC: acc_q <= acc_sat;
			ST_SQW: begin
				if (sq_done && ins_take) begin
					for (int j = 0; j < MAX_KEPT; j++) begin
						if (KEPT_CW'(j) == ins_pos) begin
							kd_q[j] <= sq_root;
							ki_q[j] <= idx_q;
						end else if (j > 0 && (KEPT_CW'(j) > ins_pos) &&
								(KEPT_CW'(j) < cnt_new)) begin
							kd_q[j] <= kd_q[(j > 0) ? j - 1 : 0];
							ki_q[j] <= ki_q[(j > 0) ? j - 1 : 0];
						end
					end
				end
			end
			ST_INVW: begin
				if (dv_done) begin
					inv_q[j_q] <= INV_W'(dv_quo);
					total_q    <= total_q + INV_W'(dv_quo);
				end
			end
			ST_NORMW: begin
				if (dv_done) begin
					result_q.bone_index <= 6'(ki_q[j_q]);
					result_q.weight     <= (dv_quo > DIV_NW'(ONE_Q16)) ? ONE_Q16 :
						dv_quo[WGT_W-1:0];
					result_q.last       <= kept_last;
				end
			end
			default: ;
		endcase
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ----- rtl/core/nbw_ram.sv -----
// nbw_ram: generic single write, single read RAM with registered read.
// Depends on nothing.
module nbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/nbw_isqrt.sv -----
// nbw_isqrt: iterative integer square root, one result bit per cycle.
// Depends on nbw_pkg.
module nbw_isqrt import nbw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   value,
	output logic              done,
	output logic [DIST_W-1:0] root
);

	logic            run_q;
	logic            done_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;

	// Control: run flag and walking bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
			end else if (run_q) begin
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = r_q[DIST_W-1:0];

endmodule

// ----- rtl/core/nbw_div.sv -----
// nbw_div: restoring divider, one quotient bit per cycle.
// Depends on nbw_pkg.
module nbw_div import nbw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] q_q;
	logic [DIV_DW:0]   trial;
	logic              fit;

	assign trial = {rem_q, q_q[DIV_NW-1]};
	assign fit   = (trial >= {1'b0, den_q});

	// Control: step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in dividend, shift out quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			q_q   <= num;
		end else if (run_q) begin
			rem_q <= fit ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			q_q   <= {q_q[DIV_NW-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ----- rtl/core/nbw_checker.sv -----
// nbw_checker: port-level checks of the nearest bone weighting block.
// Depends on nbw_pkg and assert_macros.svh; bound to the top level.
`include "assert_macros.svh"
module nbw_port_checker import nbw_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    strobe,
	input result_t result
);

	// A result only follows a cycle of query work
	`NBW_ASSERT(a_strobe_busy, clk, arst_n, !strobe || $past(busy))

	// A load beat never starts a query
	`NBW_ASSERT_NEXT(a_load_idle, clk, arst_n, start && !busy && item.command == CMD_LOAD, !busy && !strobe)

	// More results are pending after a result that is not last
	`NBW_ASSERT_NEXT(a_more_results, clk, arst_n, strobe && !result.last, busy)

	// Weights never exceed one
	`NBW_ASSERT(a_weight_range, clk, arst_n, !strobe || result.weight <= ONE_Q16)

endmodule

bind nearest_bone_weighting nbw_port_checker u_nbw_checker (.*);

// ----- verif/nbw_checker.sv -----
`timescale 1ns / 100ps
// nbw_checker: watches the command, result and register channels of the
// nearest bone weighting block, predicts each query's results and compares them.
// Depends on nbw_pkg.
module nbw_checker import nbw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  item_t                item,
	input  logic                 strobe,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]           cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam int EXP_DEPTH = 16;

	// shadow bone store and registers
	logic [31:0] shadow_x [MAX_BONES];
	logic [31:0] shadow_y [MAX_BONES];
	logic [31:0] shadow_z [MAX_BONES];
	logic [6:0]  shadow_bones;
	logic [2:0]  shadow_infl;

	// expected results, kept as a ring
	result_t     exp_mem [EXP_DEPTH];
	int          exp_wr = 0;
	int          exp_rd = 0;

	assign pending = exp_wr - exp_rd;

	// squared coordinate difference, exact in 64 bits
	function automatic longint unsigned sq_delta(logic [31:0] a, logic [31:0] b);
		logic signed [32:0] d;
		longint unsigned m;
		d = $signed({a[31], a}) - $signed({b[31], b});
		m = (d < 0) ? longint'(-d) : longint'(d);
		return m * m;
	endfunction

	function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
	endfunction

	// bit-pair integer square root, floor
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// k nearest bones of a point, then normalized inverse distance weights
	task automatic predict_weights(item_t q);
		int unsigned     nb, k, cnt, pos, i, j;
		logic [5:0]      near_idx [MAX_KEPT];
		longint unsigned near_dist [MAX_KEPT];
		longint unsigned inv [MAX_KEPT];
		longint unsigned s, d, total, w;
		result_t         r;
		nb = (shadow_bones > MAX_BONES) ? MAX_BONES : shadow_bones;
		k = (shadow_infl < 1) ? 1 : shadow_infl;
		if (k > MAX_KEPT)
			k = MAX_KEPT;
		cnt = 0;
		total = 0;
		for (i = 0; i < nb; i++) begin
			s = sq_delta(q.pos_x, shadow_x[i]);
			s = add_sat(s, sq_delta(q.pos_y, shadow_y[i]));
			s = add_sat(s, sq_delta(q.pos_z, shadow_z[i]));
			d = root_floor(s);
			// ties keep the earlier bone ahead
			pos = cnt;
			while (pos > 0 && near_dist[pos - 1] > d)
				pos--;
			if (pos < k) begin
				if (cnt < k)
					cnt++;
				for (j = cnt - 1; j > pos; j--) begin
					near_idx[j] = near_idx[j - 1];
					near_dist[j] = near_dist[j - 1];
				end
				near_idx[pos] = i[5:0];
				near_dist[pos] = d;
			end
		end
		for (i = 0; i < cnt; i++) begin
			inv[i] = (64'd1 << INV_SHIFT) / (near_dist[i] + DIST_EPS);
			total += inv[i];
		end
		for (i = 0; i < cnt; i++) begin
			w = ((inv[i] << 16) + total / 2) / total;
			if (w > ONE_Q16)
				w = ONE_Q16;
			r.bone_index = near_idx[i];
			r.weight = w[16:0];
			r.last = (i + 1 == cnt);
			exp_mem[exp_wr % EXP_DEPTH] = r;
			exp_wr++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			shadow_bones <= '0;
			shadow_infl <= 3'd4;
			for (int i = 0; i < MAX_BONES; i++) begin
				shadow_x[i] = '0;
				shadow_y[i] = '0;
				shadow_z[i] = '0;
			end
			exp_wr = 0;
			exp_rd = 0;
			errors <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_NUM_BONES)
					shadow_bones <= cfg_data;
				else if (cfg_index == CFG_MAX_INFL)
					shadow_infl <= cfg_data[2:0];
			end
			// accepted command beat
			if (start && !busy) begin
				if (item.command == CMD_LOAD) begin
					shadow_x[item.bone_slot] = item.pos_x;
					shadow_y[item.bone_slot] = item.pos_y;
					shadow_z[item.bone_slot] = item.pos_z;
				end else begin
					predict_weights(item);
				end
			end
			// result beat
			if (strobe) begin
				if (exp_wr == exp_rd) begin
					if (errors < 10)
						$display("%0t: unexpected result idx %0d w %0d last %0b", $realtime,
							result.bone_index, result.weight, result.last);
					errors <= errors + 1;
				end else begin
					exp_r = exp_mem[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (result.bone_index !== exp_r.bone_index || result.weight !== exp_r.weight
							|| result.last !== exp_r.last) begin
						if (errors < 10)
							$display("%0t: mismatch exp idx %0d w %0d last %0b, got idx %0d w %0d last %0b",
								$realtime, exp_r.bone_index, exp_r.weight, exp_r.last,
								result.bone_index, result.weight, result.last);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ----- verif/tb_nearest_bone_weighting.sv -----
`timescale 1ns / 100ps
// tb_nearest_bone_weighting: stimulus and verdict for the nearest bone
// weighting block. Depends on nbw_pkg, the block and nbw_checker.
module tb_nearest_bone_weighting;
	import nbw_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                item;
	logic                 strobe;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [6:0]           cfg_data;
	int                   errors;
	int                   pending;
	bit                   no_gaps;

	nearest_bone_weighting u_top (.*);

	nbw_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#(40_000_000);
		$display("tb_nearest_bone_weighting: FAIL");
		$finish;
	end

	// mostly small coordinates so distances spread; some full range
	function automatic logic signed [31:0] pick_coord();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 3) != 0)
			v = {{12{v[19]}}, v[19:0]};
		return v;
	endfunction

	// one command beat, after a random gap unless no_gaps is set
	task automatic send_beat(logic cmd, logic [5:0] slot, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		int gap;
		item_t it;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		it.command = cmd;
		it.bone_slot = slot;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until every expected result is in and the block is quiet
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [6:0] nb, logic [6:0] k);
		drain();
		reg_write(CFG_NUM_BONES, nb);
		reg_write(CFG_MAX_INFL, k);
	endtask

	int n_list [10] = '{1, 2, 3, 5, 8, 0, 127, 64, 12, 6};
	int k_list [10] = '{1, 4, 2, 3, 4, 4, 4, 1, 6, 5};
	int beats;

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NUM_BONES;
		cfg_data = '0;
		no_gaps = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no bones, extremes, ties, saturation, clamped counts
		send_beat(CMD_QUERY, 6'h3F, C_MAX, C_MIN, C_MAX);
		send_beat(CMD_LOAD, 6'd0, C_MIN, C_MIN, C_MIN);
		send_beat(CMD_LOAD, 6'd1, C_MAX, C_MAX, C_MAX);
		send_beat(CMD_LOAD, 6'd2, 32'sd0, 32'sd0, 32'sd0);
		send_beat(CMD_LOAD, 6'd3, 32'sd0, 32'sd0, 32'sd0);
		send_beat(CMD_LOAD, 6'd63, 32'sh5555_AAAA, 32'shAAAA_5555, 32'sh0001_0000);
		set_regs(7'd4, 7'd0);
		reg_write(CFG_SPARE_A, 7'h7F);
		reg_write(CFG_SPARE_B, 7'h55);
		send_beat(CMD_QUERY, 6'd0, C_MAX, C_MAX, C_MAX);
		send_beat(CMD_QUERY, 6'd0, 32'sd0, 32'sd0, 32'sd0);
		set_regs(7'd4, 7'd7);
		send_beat(CMD_QUERY, 6'd0, 32'sd0, 32'sd0, 32'sd0);
		send_beat(CMD_QUERY, 6'd0, C_MIN, C_MIN, C_MIN);
		send_beat(CMD_QUERY, 6'd0, C_MAX, C_MIN, 32'sd1);
		set_regs(7'd3, 7'b1111_011);
		send_beat(CMD_QUERY, 6'd0, 32'sd5, -32'sd5, 32'sd0);
		set_regs(7'd2, 7'd4);
		send_beat(CMD_QUERY, 6'd0, C_MAX, C_MAX, C_MIN);
		send_beat(CMD_QUERY, 6'd0, 32'sd0, 32'sd0, 32'sd0);

		// fill every entry before wider scans
		for (int s = 0; s < MAX_BONES; s++)
			send_beat(CMD_LOAD, s[5:0], pick_coord(), pick_coord(), pick_coord());

		// random phases over register settings
		for (int p = 0; p < 10; p++) begin
			set_regs(n_list[p][6:0], k_list[p][6:0]);
			beats = (n_list[p] >= MAX_BONES) ? 12 : 46;
			for (int b = 0; b < beats; b++) begin
				if (b % 10 == 0)
					no_gaps = ($urandom_range(0, 2) == 0);
				if (p == 3 && b == beats / 2)
					drain();
				if ($urandom_range(0, 9) < 3)
					send_beat(CMD_LOAD, 6'($urandom_range(0, 63)), pick_coord(),
						pick_coord(), pick_coord());
				else
					send_beat(CMD_QUERY, 6'($urandom_range(0, 63)), pick_coord(),
						pick_coord(), pick_coord());
			end
		end
		start <= 1'b0;

		// wait out the last results
		for (int c = 0; c < 20000 && (pending != 0 || busy); c++)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_nearest_bone_weighting: PASS");
		else
			$display("tb_nearest_bone_weighting: FAIL");
		$finish;
	end

endmodule
